// ===== design/iir_direct_form_one_filter_defines.svh =====
// Assertion macros used by the IIR direct form one filter top level.
`ifndef IIR_DIRECT_FORM_ONE_FILTER_DEFINES_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_DEFINES_SVH

`ifndef SYNTH

`define IIR_DF1_ASSERT_NOW(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion lbl failed");

`define IIR_DF1_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion lbl failed");

`else

`define IIR_DF1_ASSERT_NOW(lbl, expr)

`define IIR_DF1_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/iir_df1_pkg.sv =====
// Shared types and constants of the IIR direct form one filter.
package iir_df1_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int TAPS_W   = 2;
	localparam int INDEX_W  = 3;
	localparam int PROD_W   = SAMPLE_W + COEF_W;
	localparam int ACC_W    = PROD_W + 4;
	localparam int FRAC_SHIFT = 14;
	localparam int RESULT_W = ACC_W - FRAC_SHIFT;

	localparam logic [TAPS_W-1:0] NUM_TAPS = 2'd3;
	localparam logic [TAPS_W-1:0] DEN_TAPS = 2'd2;

	localparam logic [INDEX_W-1:0] REG_NUM_TAPS = 3'd0;
	localparam logic [INDEX_W-1:0] REG_DEN_TAPS = 3'd1;
	localparam logic [INDEX_W-1:0] REG_B0       = 3'd2;
	localparam logic [INDEX_W-1:0] REG_B1       = 3'd3;
	localparam logic [INDEX_W-1:0] REG_B2       = 3'd4;
	localparam logic [INDEX_W-1:0] REG_A1       = 3'd5;
	localparam logic [INDEX_W-1:0] REG_A2       = 3'd6;

	localparam logic signed [COEF_W-1:0] B0_RESET = 16'sd16384;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;

	typedef struct packed {
		logic [TAPS_W-1:0] num_taps_used;
		logic [TAPS_W-1:0] den_taps_used;
		coef_t             b0;
		coef_t             b1;
		coef_t             b2;
		coef_t             a1;
		coef_t             a2;
	} coef_set_t;

	typedef struct packed {
		sample_t x0;
		sample_t x1;
		sample_t x2;
		sample_t y1;
		sample_t y2;
	} taps_t;

endpackage

// ===== design/iir_df1_mac.sv =====
// Multiply-accumulate, rounding and saturation for one filter output sample.
module iir_df1_mac (
	input  iir_df1_pkg::coef_set_t coefs,
	input  iir_df1_pkg::taps_t     taps,
	output iir_df1_pkg::sample_t   y,
	output logic                   sat
);

	logic                                      use_b0, use_b1, use_b2, use_a1, use_a2;
	logic [iir_df1_pkg::TAPS_W-1:0]            den_eff;
	logic signed [iir_df1_pkg::PROD_W-1:0]     p_b0, p_b1, p_b2, p_a1, p_a2;
	logic signed [iir_df1_pkg::ACC_W-1:0]      acc;
	logic signed [iir_df1_pkg::ACC_W-1:0]      acc_rnd;
	logic signed [iir_df1_pkg::RESULT_W-1:0]   res;

	localparam logic signed [iir_df1_pkg::ACC_W-1:0] RND_HALF =
		iir_df1_pkg::ACC_W'(1) <<< (iir_df1_pkg::FRAC_SHIFT - 1);
	localparam logic signed [iir_df1_pkg::RESULT_W-1:0] RES_MAX =
		iir_df1_pkg::RESULT_W'(32767);
	localparam logic signed [iir_df1_pkg::RESULT_W-1:0] RES_MIN =
		-iir_df1_pkg::RESULT_W'(32768);

	always_comb begin
		den_eff = (coefs.den_taps_used > iir_df1_pkg::DEN_TAPS) ?
			iir_df1_pkg::DEN_TAPS : coefs.den_taps_used;
		use_b0 = coefs.num_taps_used > 2'd0;
		use_b1 = coefs.num_taps_used > 2'd1;
		use_b2 = coefs.num_taps_used > 2'd2;
		use_a1 = den_eff > 2'd0;
		use_a2 = den_eff > 2'd1;

		p_b0 = '0;
		p_b1 = '0;
		p_b2 = '0;
		p_a1 = '0;
		p_a2 = '0;
		if (use_b0) p_b0 = coefs.b0 * taps.x0;
		if (use_b1) p_b1 = coefs.b1 * taps.x1;
		if (use_b2) p_b2 = coefs.b2 * taps.x2;
		if (use_a1) p_a1 = coefs.a1 * taps.y1;
		if (use_a2) p_a2 = coefs.a2 * taps.y2;

		acc = iir_df1_pkg::ACC_W'(p_b0) + iir_df1_pkg::ACC_W'(p_b1)
			+ iir_df1_pkg::ACC_W'(p_b2) - iir_df1_pkg::ACC_W'(p_a1)
			- iir_df1_pkg::ACC_W'(p_a2);
		acc_rnd = acc + RND_HALF;
		res = acc_rnd[iir_df1_pkg::ACC_W-1:iir_df1_pkg::FRAC_SHIFT];

		if (res > RES_MAX) begin
			y   = iir_df1_pkg::sample_t'(16'sh7fff);
			sat = 1'b1;
		end else if (res < RES_MIN) begin
			y   = iir_df1_pkg::sample_t'(16'sh8000);
			sat = 1'b1;
		end else begin
			y   = res[iir_df1_pkg::SAMPLE_W-1:0];
			sat = 1'b0;
		end
	end

endmodule

// ===== design/iir_direct_form_one_filter.sv =====
// Top level of the IIR direct form one filter: registers, delay lines and stream ports.
// The filter takes one Q1.15 sample per beat and returns one rounded, saturated Q1.15
// sample per beat; a new sample is accepted in every cycle in which the output register
// is empty or being read, and each result is registered and appears in the cycle after
// its sample is taken. This rests on the feedback path: five parallel 16x16
// multipliers, the sum, rounding and clipping all sit between the delay-line registers
// and the output register, so y[n-1] is ready for the next sample. Coefficients (Q2.14)
// and tap counts are written through the configuration channel, which is always ready
// and should be used only while the filter is idle.
`include "iir_direct_form_one_filter_defines.svh"

module iir_direct_form_one_filter (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [iir_df1_pkg::SAMPLE_W-1:0]       s_tdata,  // [15:0] sample_in
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [iir_df1_pkg::SAMPLE_W-1:0]       m_tdata,  // [15:0] sample_out
	output logic                                   m_tuser,  // [0] saturated
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [iir_df1_pkg::INDEX_W-1:0]        cfg_index,
	input  logic [iir_df1_pkg::COEF_W-1:0]         cfg_data
);

	iir_df1_pkg::coef_set_t coefs_q;
	iir_df1_pkg::sample_t   x1_q, x2_q, y1_q, y2_q;
	iir_df1_pkg::taps_t     taps;
	iir_df1_pkg::sample_t   y_new;
	logic                   sat_new;
	logic                   out_valid_q;
	iir_df1_pkg::sample_t   out_data_q;
	logic                   out_sat_q;
	logic                   in_beat;

	assign s_tready  = !out_valid_q || m_tready;
	assign in_beat   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_sat_q;

	assign taps.x0 = s_tdata;
	assign taps.x1 = x1_q;
	assign taps.x2 = x2_q;
	assign taps.y1 = y1_q;
	assign taps.y2 = y2_q;

	iir_df1_mac u_mac (
		.coefs (coefs_q),
		.taps  (taps),
		.y     (y_new),
		.sat   (sat_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.num_taps_used <= iir_df1_pkg::NUM_TAPS;
			coefs_q.den_taps_used <= '0;
			coefs_q.b0            <= iir_df1_pkg::B0_RESET;
			coefs_q.b1            <= '0;
			coefs_q.b2            <= '0;
			coefs_q.a1            <= '0;
			coefs_q.a2            <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				iir_df1_pkg::REG_NUM_TAPS: coefs_q.num_taps_used <= cfg_data[iir_df1_pkg::TAPS_W-1:0];
				iir_df1_pkg::REG_DEN_TAPS: coefs_q.den_taps_used <= cfg_data[iir_df1_pkg::TAPS_W-1:0];
				iir_df1_pkg::REG_B0:       coefs_q.b0 <= cfg_data;
				iir_df1_pkg::REG_B1:       coefs_q.b1 <= cfg_data;
				iir_df1_pkg::REG_B2:       coefs_q.b2 <= cfg_data;
				iir_df1_pkg::REG_A1:       coefs_q.a1 <= cfg_data;
				iir_df1_pkg::REG_A2:       coefs_q.a2 <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (in_beat) begin
			x1_q <= s_tdata;
			x2_q <= x1_q;
			y1_q <= y_new;
			y2_q <= y1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_beat) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			out_data_q <= y_new;
			out_sat_q  <= sat_new;
		end
	end

	`IIR_DF1_ASSERT_NEXT(a_beat_gives_result, in_beat, m_tvalid)
	`IIR_DF1_ASSERT_NEXT(a_feedback_matches_out, in_beat, y1_q == out_data_q)
	`IIR_DF1_ASSERT_NEXT(a_input_delay, in_beat, x1_q == $past(s_tdata))
	`IIR_DF1_ASSERT_NOW(a_sat_is_clipped, !(m_tvalid && m_tuser) || m_tdata == 16'h7fff || m_tdata == 16'h8000)

endmodule
